[rtl/mpbd_pkg.sv]
// mpbd_pkg: shared widths, frame state codes and result types for the
// motion phase boundary detector; no dependencies
package mpbd_pkg;

    // widths of samples, frame index and configuration
    localparam int SAMPLE_BITS    = 16;
    localparam int FRAME_BITS     = 20;
    localparam int OUT_FRAME_BITS = 20;
    localparam int GAIN_BITS      = 12;
    localparam int GAIN_FRAC_BITS = 8;

    // comparison width: magnitude * 256 against gain * spread
    localparam int MAG_BITS  = SAMPLE_BITS + 1;
    localparam int LHS_BITS  = MAG_BITS + GAIN_FRAC_BITS;
    localparam int RHS_BITS  = GAIN_BITS + SAMPLE_BITS;
    localparam int CMP_BITS  = (LHS_BITS > RHS_BITS) ? LHS_BITS : RHS_BITS;

    // frame index widened to cover both the counter and the output field
    localparam int FRAME_EXT_BITS =
        (FRAME_BITS > OUT_FRAME_BITS) ? FRAME_BITS : OUT_FRAME_BITS;

    localparam logic [GAIN_BITS-1:0]  GAIN_RESET = GAIN_BITS'(256);
    localparam logic [FRAME_BITS-1:0] FRAME_MAX  = {FRAME_BITS{1'b1}};

    // frame classification codes
    typedef enum logic [1:0] {
        ST_RESTING  = 2'd0,
        ST_COASTING = 2'd1,
        ST_DRIVEN   = 2'd2,
        ST_HELD     = 2'd3
    } t_frame_state;

    // one result word
    typedef struct packed {
        t_frame_state              frame_state;
        logic                      boundary_valid;
        logic [OUT_FRAME_BITS-1:0] boundary_frame;
        logic                      boundary_at_rest;
    } t_result;

endpackage

[rtl/mpbd_in_if.sv]
// mpbd_in_if: valid/ready channel carrying one motion frame word
// depends on mpbd_pkg
interface mpbd_in_if;
    logic                                    valid;
    logic                                    ready;
    logic signed [mpbd_pkg::SAMPLE_BITS-1:0] velocity;
    logic        [mpbd_pkg::SAMPLE_BITS-1:0] velocity_spread;
    logic signed [mpbd_pkg::SAMPLE_BITS-1:0] acceleration;
    logic        [mpbd_pkg::SAMPLE_BITS-1:0] acceleration_spread;
    logic                                    last_frame;

    modport source (
        output valid, velocity, velocity_spread, acceleration,
               acceleration_spread, last_frame,
        input  ready
    );
    modport sink (
        input  valid, velocity, velocity_spread, acceleration,
               acceleration_spread, last_frame,
        output ready
    );
endinterface

[rtl/mpbd_out_if.sv]
// mpbd_out_if: valid/ready channel carrying one classification result word
// depends on mpbd_pkg
interface mpbd_out_if;
    logic                                    valid;
    logic                                    ready;
    logic [1:0]                              frame_state;
    logic                                    boundary_valid;
    logic [mpbd_pkg::OUT_FRAME_BITS-1:0]     boundary_frame;
    logic                                    boundary_at_rest;

    modport source (
        output valid, frame_state, boundary_valid, boundary_frame,
               boundary_at_rest,
        input  ready
    );
    modport sink (
        input  valid, frame_state, boundary_valid, boundary_frame,
               boundary_at_rest,
        output ready
    );
endinterface

[rtl/mpbd_classify.sv]
// mpbd_classify: sorts one frame into resting, coasting, driven or held back
// with two gain-times-spread compares; depends on mpbd_pkg
module mpbd_classify (
    input  logic signed [mpbd_pkg::SAMPLE_BITS-1:0] i_velocity,
    input  logic        [mpbd_pkg::SAMPLE_BITS-1:0] i_velocity_spread,
    input  logic signed [mpbd_pkg::SAMPLE_BITS-1:0] i_acceleration,
    input  logic        [mpbd_pkg::SAMPLE_BITS-1:0] i_acceleration_spread,
    input  logic        [mpbd_pkg::GAIN_BITS-1:0]   i_gain,
    output mpbd_pkg::t_frame_state                  o_state
);
    localparam int SB = mpbd_pkg::SAMPLE_BITS;

    logic [SB:0]                       w_vel_ext;
    logic [SB:0]                       w_acc_ext;
    logic [mpbd_pkg::MAG_BITS-1:0]     w_vel_mag;
    logic [mpbd_pkg::MAG_BITS-1:0]     w_acc_mag;
    logic [mpbd_pkg::RHS_BITS-1:0]     w_vel_lim;
    logic [mpbd_pkg::RHS_BITS-1:0]     w_acc_lim;
    logic                              w_vel_def;
    logic                              w_acc_def;
    logic                              w_vel_neg;
    logic                              w_acc_neg;

    // magnitudes, one bit wider so the most negative sample fits
    assign w_vel_neg = i_velocity[SB-1];
    assign w_acc_neg = i_acceleration[SB-1];
    assign w_vel_ext = {w_vel_neg, $unsigned(i_velocity)};
    assign w_acc_ext = {w_acc_neg, $unsigned(i_acceleration)};
    assign w_vel_mag = w_vel_neg ? (~w_vel_ext + 1'b1) : w_vel_ext;
    assign w_acc_mag = w_acc_neg ? (~w_acc_ext + 1'b1) : w_acc_ext;

    // gain times spread
    assign w_vel_lim = mpbd_pkg::RHS_BITS'(i_gain) * mpbd_pkg::RHS_BITS'(i_velocity_spread);
    assign w_acc_lim = mpbd_pkg::RHS_BITS'(i_gain)
                     * mpbd_pkg::RHS_BITS'(i_acceleration_spread);

    // definite motion: magnitude * 256 above the limit
    assign w_vel_def = mpbd_pkg::CMP_BITS'({w_vel_mag, {mpbd_pkg::GAIN_FRAC_BITS{1'b0}}})
                     > mpbd_pkg::CMP_BITS'(w_vel_lim);
    assign w_acc_def = mpbd_pkg::CMP_BITS'({w_acc_mag, {mpbd_pkg::GAIN_FRAC_BITS{1'b0}}})
                     > mpbd_pkg::CMP_BITS'(w_acc_lim);

    // state select
    always_comb begin
        if (!w_vel_def) begin
            o_state = mpbd_pkg::ST_RESTING;
        end else if (!w_acc_def) begin
            o_state = mpbd_pkg::ST_COASTING;
        end else if (w_vel_neg == w_acc_neg) begin
            o_state = mpbd_pkg::ST_DRIVEN;
        end else begin
            o_state = mpbd_pkg::ST_HELD;
        end
    end

endmodule

[rtl/mpbd_trip.sv]
// mpbd_trip: trip flags, frame counter and boundary report for one frame
// depends on mpbd_pkg
module mpbd_trip (
    input  logic                   i_clk,
    input  logic                   i_rst_n,
    input  logic                   i_step,
    input  mpbd_pkg::t_frame_state i_state,
    input  logic                   i_last_frame,
    output mpbd_pkg::t_result      o_result
);
    localparam int FB = mpbd_pkg::FRAME_BITS;

    logic [FB-1:0] r_frame_cnt;
    logic [FB-1:0] n_frame_cnt;
    logic          r_driven;
    logic          n_driven;
    logic          r_held;
    logic          n_held;

    logic [FB-1:0]                       w_prev;
    logic [FB-1:0]                       w_bframe;
    logic [mpbd_pkg::FRAME_EXT_BITS-1:0] w_bframe_ext;
    logic                                w_valid;
    logic                                w_at_rest;
    logic                                w_mid_driven;
    logic                                w_mid_held;

    assign w_prev = (r_frame_cnt == '0) ? '0 : (r_frame_cnt - 1'b1);

    // flag update, boundary report and end-of-session flush
    always_comb begin
        w_valid      = 1'b0;
        w_at_rest    = 1'b0;
        w_bframe     = '0;
        w_mid_driven = r_driven;
        w_mid_held   = r_held;
        case (i_state)
            mpbd_pkg::ST_RESTING: begin
                if (r_held) begin
                    w_valid   = 1'b1;
                    w_bframe  = w_prev;
                    w_at_rest = 1'b1;
                end
                w_mid_driven = 1'b0;
                w_mid_held   = 1'b0;
            end
            mpbd_pkg::ST_DRIVEN: begin
                if (r_held) begin
                    w_valid  = 1'b1;
                    w_bframe = w_prev;
                end
                w_mid_driven = 1'b1;
                w_mid_held   = 1'b0;
            end
            mpbd_pkg::ST_HELD: begin
                if (r_driven) begin
                    w_mid_held = 1'b1;
                end
            end
            default: begin
            end
        endcase

        if (i_last_frame) begin
            if (w_mid_held) begin
                w_valid   = 1'b1;
                w_bframe  = r_frame_cnt;
                w_at_rest = 1'b1;
            end
            n_frame_cnt = '0;
            n_driven    = 1'b0;
            n_held      = 1'b0;
        end else begin
            n_frame_cnt = (r_frame_cnt != mpbd_pkg::FRAME_MAX)
                        ? (r_frame_cnt + 1'b1) : r_frame_cnt;
            n_driven    = w_mid_driven;
            n_held      = w_mid_held;
        end
    end

    // low bits of the index go out
    assign w_bframe_ext = mpbd_pkg::FRAME_EXT_BITS'(w_bframe);

    assign o_result.frame_state      = i_state;
    assign o_result.boundary_valid   = w_valid;
    assign o_result.boundary_frame   = w_bframe_ext[mpbd_pkg::OUT_FRAME_BITS-1:0];
    assign o_result.boundary_at_rest = w_at_rest;

    // state registers advance once per frame
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_frame_cnt <= '0;
            r_driven    <= 1'b0;
            r_held      <= 1'b0;
        end else if (i_step) begin
            r_frame_cnt <= n_frame_cnt;
            r_driven    <= n_driven;
            r_held      <= n_held;
        end
    end

endmodule

[rtl/motion_phase_boundary_detector.sv]
// motion_phase_boundary_detector: top level with input register, classifier,
// trip tracker and result register; depends on mpbd_pkg, mpbd_in_if,
// mpbd_out_if, mpbd_classify and mpbd_trip
//
// Usage:
//   i_in carries one motion frame word per handshake (valid and ready high
//   at a rising edge). o_out returns exactly one result word per frame, in
//   order: frame state and, when a trip closes, the boundary frame index.
//   i_cfg_we / i_cfg_wdata write the 12-bit Q4.8 gain; write it only while
//   no frame is in flight.
//   Path: the input register takes the word at the accepting edge, and the
//   result register takes the classified word when the pipeline advances;
//   o_out valid rises as the result register is loaded. Throughput is one
//   word per cycle while the receiver keeps taking results, set by the gain
//   multiply and compare path between the two registers.
//   Reset (synchronous, active low) empties both registers, clears the
//   frame counter and trip flags and loads the gain with 1.0 (256).
//   When the receiver stalls the result word holds; the input register
//   still takes one more word, then ready drops until the result is taken.
module motion_phase_boundary_detector (
    input  logic                            i_clk,
    input  logic                            i_rst_n,
    input  logic                            i_cfg_we,
    input  logic [mpbd_pkg::GAIN_BITS-1:0]  i_cfg_wdata,
    mpbd_in_if.sink                         i_in,
    mpbd_out_if.source                      o_out
);
    localparam int SB = mpbd_pkg::SAMPLE_BITS;

    logic [mpbd_pkg::GAIN_BITS-1:0] r_gain;

    logic                    r_in_vld;
    logic signed [SB-1:0]    r_velocity;
    logic        [SB-1:0]    r_velocity_spread;
    logic signed [SB-1:0]    r_acceleration;
    logic        [SB-1:0]    r_acceleration_spread;
    logic                    r_last_frame;

    logic                    r_out_vld;
    mpbd_pkg::t_result       r_result;

    logic                    w_adv;
    logic                    w_in_ready;
    logic                    w_step;
    mpbd_pkg::t_frame_state  w_state;
    mpbd_pkg::t_result       w_result;

    // pipeline advance whenever the result register is free or being taken
    assign w_adv      = !r_out_vld || o_out.ready;
    assign w_in_ready = !r_in_vld || w_adv;
    assign w_step     = w_adv && r_in_vld;
    assign i_in.ready = w_in_ready;

    // gain register
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_gain <= mpbd_pkg::GAIN_RESET;
        end else if (i_cfg_we) begin
            r_gain <= i_cfg_wdata;
        end
    end

    // valid bits of the two stages
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_in_vld  <= 1'b0;
            r_out_vld <= 1'b0;
        end else begin
            if (w_in_ready) begin
                r_in_vld <= i_in.valid;
            end
            if (w_adv) begin
                r_out_vld <= r_in_vld;
            end
        end
    end

    // input word register
    always_ff @(posedge i_clk) begin
        if (i_in.valid && w_in_ready) begin
            r_velocity            <= i_in.velocity;
            r_velocity_spread     <= i_in.velocity_spread;
            r_acceleration        <= i_in.acceleration;
            r_acceleration_spread <= i_in.acceleration_spread;
            r_last_frame          <= i_in.last_frame;
        end
    end

    // classification
    mpbd_classify u_classify (
        .i_velocity            (r_velocity),
        .i_velocity_spread     (r_velocity_spread),
        .i_acceleration        (r_acceleration),
        .i_acceleration_spread (r_acceleration_spread),
        .i_gain                (r_gain),
        .o_state               (w_state)
    );

    // trip tracking
    mpbd_trip u_trip (
        .i_clk        (i_clk),
        .i_rst_n      (i_rst_n),
        .i_step       (w_step),
        .i_state      (w_state),
        .i_last_frame (r_last_frame),
        .o_result     (w_result)
    );

    // result word register
    always_ff @(posedge i_clk) begin
        if (w_step) begin
            r_result <= w_result;
        end
    end

    assign o_out.valid            = r_out_vld;
    assign o_out.frame_state      = r_result.frame_state;
    assign o_out.boundary_valid   = r_result.boundary_valid;
    assign o_out.boundary_frame   = r_result.boundary_frame;
    assign o_out.boundary_at_rest = r_result.boundary_at_rest;

    // no boundary means zero boundary fields
    a_quiet_fields: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_out_vld && !r_result.boundary_valid)
        |-> (r_result.boundary_frame == '0 && !r_result.boundary_at_rest))
        else $error("boundary fields set without a boundary");

    // a trip ended by a new drive only on a driven frame
    a_drive_end: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_out_vld && r_result.boundary_valid && !r_result.boundary_at_rest)
        |-> (r_result.frame_state == mpbd_pkg::ST_DRIVEN))
        else $error("drive boundary on a frame that is not driven");

    // a boundary on a resting frame is always at rest
    a_rest_end: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_out_vld && r_result.boundary_valid
         && r_result.frame_state == mpbd_pkg::ST_RESTING)
        |-> r_result.boundary_at_rest)
        else $error("resting frame closed a trip not at rest");

endmodule

[verif/motion_phase_boundary_detector_chk.sv]
// motion_phase_boundary_detector_chk: watches the frame and result channels,
// predicts each result word from its own copy of gain, frame index and trip flags,
// and compares field by field; depends on mpbd_pkg, mpbd_in_if, mpbd_out_if
module motion_phase_boundary_detector_chk (
    input  logic                           i_clk,
    input  logic                           i_rst_n,
    input  logic                           i_cfg_we,
    input  logic [mpbd_pkg::GAIN_BITS-1:0] i_cfg_wdata,
    mpbd_in_if                             i_in_mon,
    mpbd_out_if                            i_out_mon,
    output int                             o_err_count,
    output int                             o_pending
);

    // predicted result words, oldest first
    mpbd_pkg::t_result                  expected_words[$];

    // shadow of the block state
    logic [mpbd_pkg::GAIN_BITS-1:0]     gain_k;
    logic [mpbd_pkg::FRAME_BITS-1:0]    frame_idx;
    logic                               trip_driven;
    logic                               trip_held;
    int                                 err_count = 0;

    function automatic logic [mpbd_pkg::MAG_BITS-1:0] magnitude_of(
        input logic [mpbd_pkg::SAMPLE_BITS-1:0] s);
        return s[mpbd_pkg::SAMPLE_BITS-1] ? (mpbd_pkg::MAG_BITS'(0) - {1'b1, s})
                                          : {1'b0, s};
    endfunction

    // |x| * 256 strictly above gain * spread, exact at full width
    function automatic bit is_definite(input logic [mpbd_pkg::MAG_BITS-1:0] mag,
                                       input logic [mpbd_pkg::SAMPLE_BITS-1:0] spread);
        return 64'({mag, mpbd_pkg::GAIN_FRAC_BITS'(0)}) > (64'(gain_k) * 64'(spread));
    endfunction

    // classify one frame, advance trip flags and frame index, return the word
    function automatic mpbd_pkg::t_result track_frame(
        input logic [mpbd_pkg::SAMPLE_BITS-1:0] vel,
        input logic [mpbd_pkg::SAMPLE_BITS-1:0] vel_sd,
        input logic [mpbd_pkg::SAMPLE_BITS-1:0] acc,
        input logic [mpbd_pkg::SAMPLE_BITS-1:0] acc_sd,
        input logic last);
        mpbd_pkg::t_result               res;
        mpbd_pkg::t_frame_state          cls;
        logic [mpbd_pkg::FRAME_BITS-1:0] prev_idx;

        res      = '0;
        prev_idx = (frame_idx == '0) ? '0 : frame_idx - 1'b1;

        if (!is_definite(magnitude_of(vel), vel_sd))
            cls = mpbd_pkg::ST_RESTING;
        else if (!is_definite(magnitude_of(acc), acc_sd))
            cls = mpbd_pkg::ST_COASTING;
        else
            cls = (vel[mpbd_pkg::SAMPLE_BITS-1] == acc[mpbd_pkg::SAMPLE_BITS-1])
                ? mpbd_pkg::ST_DRIVEN : mpbd_pkg::ST_HELD;
        res.frame_state = cls;

        // trip tracking: a held trip closes on rest or on a new drive
        case (cls)
            mpbd_pkg::ST_RESTING: begin
                if (trip_held) begin
                    res.boundary_valid   = 1'b1;
                    res.boundary_frame   = mpbd_pkg::OUT_FRAME_BITS'(prev_idx);
                    res.boundary_at_rest = 1'b1;
                end
                trip_driven = 1'b0;
                trip_held   = 1'b0;
            end
            mpbd_pkg::ST_DRIVEN: begin
                if (trip_held) begin
                    res.boundary_valid   = 1'b1;
                    res.boundary_frame   = mpbd_pkg::OUT_FRAME_BITS'(prev_idx);
                    res.boundary_at_rest = 1'b0;
                end
                trip_driven = 1'b1;
                trip_held   = 1'b0;
            end
            mpbd_pkg::ST_HELD: begin
                if (trip_driven)
                    trip_held = 1'b1;
            end
            default: ;
        endcase

        // session end flushes a still-held trip at the current frame
        if (last) begin
            if (trip_held) begin
                res.boundary_valid   = 1'b1;
                res.boundary_frame   = mpbd_pkg::OUT_FRAME_BITS'(frame_idx);
                res.boundary_at_rest = 1'b1;
            end
            frame_idx   = '0;
            trip_driven = 1'b0;
            trip_held   = 1'b0;
        end else if (frame_idx != mpbd_pkg::FRAME_MAX) begin
            frame_idx = frame_idx + 1'b1;
        end
        return res;
    endfunction

    task automatic check_field(input string name, input int unsigned want,
                               input int unsigned got);
        if (want != got) begin
            err_count++;
            $display("%0t mismatch %s: expected %0d, got %0d", $time, name, want, got);
        end
    endtask

    // compare result words, then record config writes and new frame words
    always @(posedge i_clk) begin
        mpbd_pkg::t_result want;
        mpbd_pkg::t_result pred;
        if (!i_rst_n) begin
            gain_k      = mpbd_pkg::GAIN_RESET;
            frame_idx   = '0;
            trip_driven = 1'b0;
            trip_held   = 1'b0;
            expected_words.delete();
        end else begin
            if (i_out_mon.valid && i_out_mon.ready) begin
                if (expected_words.size() == 0) begin
                    err_count++;
                    $display("%0t result word with nothing pending", $time);
                end else begin
                    want = expected_words.pop_front();
                    check_field("frame_state", want.frame_state, i_out_mon.frame_state);
                    check_field("boundary_valid", want.boundary_valid,
                                i_out_mon.boundary_valid);
                    check_field("boundary_frame", want.boundary_frame,
                                i_out_mon.boundary_frame);
                    check_field("boundary_at_rest", want.boundary_at_rest,
                                i_out_mon.boundary_at_rest);
                end
            end
            if (i_cfg_we)
                gain_k = i_cfg_wdata;
            if (i_in_mon.valid && i_in_mon.ready) begin
                pred = track_frame(i_in_mon.velocity,
                                   i_in_mon.velocity_spread,
                                   i_in_mon.acceleration,
                                   i_in_mon.acceleration_spread,
                                   i_in_mon.last_frame);
                expected_words.insert(expected_words.size(), pred);
            end
        end
        o_pending   <= expected_words.size();
        o_err_count <= err_count;
    end

endmodule

[verif/motion_phase_boundary_detector_tb.sv]
// motion_phase_boundary_detector_tb: drives frame words, gain writes and result
// back-pressure, and reports the verdict from the checker's error count;
// depends on mpbd_pkg, both channel interfaces, the block and its checker
module motion_phase_boundary_detector_tb;

    localparam int          PHASES     = 6;
    localparam int unsigned PHASE_WORDS = 100;
    localparam int unsigned PHASE_IDLE[PHASES]  = '{0, 78, 0, 10, 78, 0};
    localparam int unsigned PHASE_STALL[PHASES] = '{0, 0, 78, 10, 0, 78};

    // one frame word as the sender sees it
    typedef struct {
        logic [mpbd_pkg::SAMPLE_BITS-1:0] velocity;
        logic [mpbd_pkg::SAMPLE_BITS-1:0] velocity_spread;
        logic [mpbd_pkg::SAMPLE_BITS-1:0] acceleration;
        logic [mpbd_pkg::SAMPLE_BITS-1:0] acceleration_spread;
        logic                             last_frame;
    } t_frame;

    logic                           clk   = 1'b0;
    logic                           rst_n = 1'b0;
    logic                           cfg_we;
    logic [mpbd_pkg::GAIN_BITS-1:0] cfg_wdata;
    logic                           out_ready = 1'b0;
    logic [mpbd_pkg::GAIN_BITS-1:0] gain_k = mpbd_pkg::GAIN_RESET;
    int unsigned                    idle_pct  = 0;
    int unsigned                    stall_pct = 0;
    int unsigned                    sent = 0;
    int                             err_count;
    int                             pending;

    mpbd_in_if  in_if ();
    mpbd_out_if out_if ();

    assign out_if.ready = out_ready;

    motion_phase_boundary_detector i_dut (
        .i_clk       (clk),
        .i_rst_n     (rst_n),
        .i_cfg_we    (cfg_we),
        .i_cfg_wdata (cfg_wdata),
        .i_in        (in_if),
        .o_out       (out_if)
    );

    motion_phase_boundary_detector_chk i_chk (
        .i_clk       (clk),
        .i_rst_n     (rst_n),
        .i_cfg_we    (cfg_we),
        .i_cfg_wdata (cfg_wdata),
        .i_in_mon    (in_if),
        .i_out_mon   (out_if),
        .o_err_count (err_count),
        .o_pending   (pending)
    );

    always begin
        #6 clk = 1'b1;
        #6 clk = 1'b0;
    end

    // receiver back-pressure
    always @(posedge clk) begin
        out_ready <= ($urandom_range(99) >= stall_pct);
    end

    // watchdog
    initial begin
        #(64'd2_400_000);
        $display("FAIL");
        $finish;
    end

    // offer one word, with random idle cycles ahead of it, until accepted
    task automatic send_frame(input t_frame f);
        while ($urandom_range(99) < idle_pct) begin
            in_if.valid <= 1'b0;
            @(posedge clk);
        end
        in_if.valid               <= 1'b1;
        in_if.velocity            <= f.velocity;
        in_if.velocity_spread     <= f.velocity_spread;
        in_if.acceleration        <= f.acceleration;
        in_if.acceleration_spread <= f.acceleration_spread;
        in_if.last_frame          <= f.last_frame;
        @(posedge clk);
        while (!in_if.ready) @(posedge clk);
        sent++;
    endtask

    task automatic send_directed(input int vel, input int vel_sd, input int acc,
                                 input int acc_sd, input bit last);
        t_frame f;
        f.velocity            = mpbd_pkg::SAMPLE_BITS'(vel);
        f.velocity_spread     = mpbd_pkg::SAMPLE_BITS'(vel_sd);
        f.acceleration        = mpbd_pkg::SAMPLE_BITS'(acc);
        f.acceleration_spread = mpbd_pkg::SAMPLE_BITS'(acc_sd);
        f.last_frame          = last;
        send_frame(f);
    endtask

    // stop sending and wait until every predicted word has come back
    task automatic wait_drained();
        in_if.valid <= 1'b0;
        @(posedge clk);
        while (pending != 0) @(posedge clk);
    endtask

    task automatic write_gain(input logic [mpbd_pkg::GAIN_BITS-1:0] k);
        wait_drained();
        repeat (4) @(posedge clk);
        cfg_we    <= 1'b1;
        cfg_wdata <= k;
        gain_k     = k;
        @(posedge clk);
        cfg_we    <= 1'b0;
    endtask

    // magnitude and spread that land on the wanted side of the gain test,
    // often right at the threshold
    function automatic void pick_pair(input bit moving,
                                      output logic [mpbd_pkg::MAG_BITS-1:0] mag,
                                      output logic [mpbd_pkg::SAMPLE_BITS-1:0] spread);
        int unsigned k, m, lim;
        k = gain_k;
        if (moving) begin
            m = $urandom_range(32767, 1);
            lim = (k == 0) ? 65535 : (m * 256 - 1) / k;
            if (lim > 65535)
                lim = 65535;
            spread = ($urandom_range(3) == 0) ? lim : $urandom_range(lim, 0);
        end else begin
            lim = (65535 * k) / 256;
            if (lim > 32767)
                lim = 32767;
            m = $urandom_range(lim, 0);
            lim = (k == 0) ? 0 : (m * 256 + k - 1) / k;
            spread = ($urandom_range(3) == 0) ? lim : $urandom_range(65535, lim);
        end
        mag = mpbd_pkg::MAG_BITS'(m);
    endfunction

    // well-formed frame of the given class under the current gain
    function automatic t_frame make_frame(input mpbd_pkg::t_frame_state cls,
                                          input logic last);
        t_frame                        f;
        logic [mpbd_pkg::MAG_BITS-1:0] vm, am;
        logic                          vneg, aneg;
        bit                            acc_moving;
        if (cls == mpbd_pkg::ST_DRIVEN || cls == mpbd_pkg::ST_HELD)
            acc_moving = 1'b1;
        else if (cls == mpbd_pkg::ST_COASTING)
            acc_moving = 1'b0;
        else
            acc_moving = 1'($urandom_range(1));
        pick_pair(cls != mpbd_pkg::ST_RESTING, vm, f.velocity_spread);
        pick_pair(acc_moving, am, f.acceleration_spread);
        vneg = 1'($urandom_range(1));
        if (cls == mpbd_pkg::ST_HELD)
            aneg = !vneg;
        else if (cls == mpbd_pkg::ST_DRIVEN)
            aneg = vneg;
        else
            aneg = 1'($urandom_range(1));
        f.velocity     = mpbd_pkg::SAMPLE_BITS'(vneg ? (mpbd_pkg::MAG_BITS'(0) - vm) : vm);
        f.acceleration = mpbd_pkg::SAMPLE_BITS'(aneg ? (mpbd_pkg::MAG_BITS'(0) - am) : am);
        f.last_frame   = last;
        return f;
    endfunction

    // fully random frame
    function automatic t_frame random_frame(input bit allow_last);
        t_frame f;
        f.velocity            = mpbd_pkg::SAMPLE_BITS'($urandom);
        f.velocity_spread     = mpbd_pkg::SAMPLE_BITS'($urandom);
        f.acceleration        = mpbd_pkg::SAMPLE_BITS'($urandom);
        f.acceleration_spread = mpbd_pkg::SAMPLE_BITS'($urandom);
        f.last_frame          = allow_last && ($urandom_range(15) == 0);
        return f;
    endfunction

    // one trip: optional rest, drive, optional coast, hold back, optional coast, then an optional random closing frame
    task automatic send_trip();
        repeat ($urandom_range(2)) send_frame(make_frame(mpbd_pkg::ST_RESTING, 1'b0));
        repeat ($urandom_range(3, 1)) send_frame(make_frame(mpbd_pkg::ST_DRIVEN, 1'b0));
        repeat ($urandom_range(2)) send_frame(make_frame(mpbd_pkg::ST_COASTING, 1'b0));
        repeat ($urandom_range(3, 1)) send_frame(make_frame(mpbd_pkg::ST_HELD, 1'b0));
        repeat ($urandom_range(1)) send_frame(make_frame(mpbd_pkg::ST_COASTING, 1'b0));
        case ($urandom_range(3))
            0: send_frame(make_frame(mpbd_pkg::ST_RESTING, 1'b0));
            1: send_frame(make_frame(mpbd_pkg::ST_DRIVEN, 1'b0));
            2: send_frame(make_frame(mpbd_pkg::t_frame_state'($urandom_range(3)), 1'b1));
            default: ;
        endcase
    endtask

    initial begin
        int unsigned start;
        bit          paused;
        int unsigned pick;

        in_if.valid               = 1'b0;
        in_if.velocity            = '0;
        in_if.velocity_spread     = '0;
        in_if.acceleration        = '0;
        in_if.acceleration_spread = '0;
        in_if.last_frame          = 1'b0;
        cfg_we                    = 1'b0;
        cfg_wdata                 = '0;

        repeat (8) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        // directed frames at the reset gain of 1.0
        send_directed(0, 0, 0, 0, 1'b0);                 // all zero is resting
        send_directed(100, 100, 7, 0, 1'b0);             // equal products stay resting
        send_directed(101, 100, 50, 50, 1'b0);           // moving, accel at threshold
        send_directed(32767, 0, 32767, 0, 1'b0);         // driven at positive extremes
        send_directed(-32768, 65535, 32767, 65535, 1'b0); // most negative, wide spread
        send_directed(-32768, 0, -32768, 0, 1'b0);       // driven, both most negative
        send_directed(-32768, 127, 32767, 127, 1'b0);    // held back after drive
        send_directed(1000, 0, 0, 65535, 1'b0);          // coasting keeps the trip
        send_directed(0, 0, 0, 0, 1'b0);                 // rest closes trip
        send_directed(500, 0, -500, 0, 1'b0);            // held back with no drive
        send_directed(0, 65535, 0, 65535, 1'b0);         // rest, no boundary
        send_directed(-1000, 0, -1, 0, 1'b0);            // driven
        send_directed(-1000, 0, 1, 0, 1'b0);             // held
        send_directed(1000, 0, 1000, 0, 1'b0);           // new drive closes trip
        send_directed(1, 0, -1, 0, 1'b0);                // held
        send_directed(1, 0, 0, 0, 1'b1);                 // session end flushes trip
        send_directed(200, 0, 300, 0, 1'b0);             // driven at frame zero
        send_directed(200, 0, -300, 0, 1'b0);            // held
        send_directed(0, 0, 0, 0, 1'b1);                 // rest on last, single boundary
        send_directed(-5, 0, -5, 0, 1'b0);
        send_directed(-5, 0, 5, 0, 1'b0);
        send_directed(5, 0, 5, 0, 1'b1);                 // drive on last, single boundary
        send_directed(5, 0, -5, 0, 1'b1);                // held without drive on last
        send_directed(-1, 65535, 32767, 65535, 1'b0);
        send_directed(32767, 32767, -32768, 32768, 1'b1);

        // random phases: gain extremes and random gains, varying idle patterns
        for (int p = 0; p < PHASES; p++) begin
            case (p)
                0:       write_gain('0);
                1:       write_gain('1);
                3:       write_gain(mpbd_pkg::GAIN_BITS'(1));
                default: write_gain(mpbd_pkg::GAIN_BITS'($urandom_range(4095)));
            endcase
            idle_pct  = PHASE_IDLE[p];
            stall_pct = PHASE_STALL[p];
            start     = sent;
            paused    = 1'b0;
            while (sent - start < PHASE_WORDS) begin
                // hold off mid-phase until every result is back
                if (!paused && sent - start >= PHASE_WORDS / 2) begin
                    wait_drained();
                    paused = 1'b1;
                end
                pick = $urandom_range(9);
                if (pick < 7)
                    send_trip();
                else if (pick < 9)
                    send_frame(random_frame(1'b1));
                else
                    send_frame(make_frame(mpbd_pkg::t_frame_state'($urandom_range(3)), 1'b1));
            end
        end

        // closing trips at the reset gain and full rate
        write_gain(mpbd_pkg::GAIN_RESET);
        idle_pct  = 0;
        stall_pct = 0;
        send_frame(make_frame(mpbd_pkg::ST_RESTING, 1'b1));
        send_frame(make_frame(mpbd_pkg::ST_DRIVEN, 1'b0));
        send_frame(make_frame(mpbd_pkg::ST_HELD, 1'b0));
        send_frame(make_frame(mpbd_pkg::ST_RESTING, 1'b0));
        send_frame(make_frame(mpbd_pkg::ST_DRIVEN, 1'b0));
        send_frame(make_frame(mpbd_pkg::ST_HELD, 1'b0));
        send_frame(make_frame(mpbd_pkg::ST_DRIVEN, 1'b0));
        send_frame(make_frame(mpbd_pkg::ST_HELD, 1'b0));
        send_frame(make_frame(mpbd_pkg::ST_COASTING, 1'b1));

        wait_drained();
        repeat (8) @(posedge clk);
        if (err_count == 0 && pending == 0)
            $display("PASS");
        else
            $display("FAIL");
        $finish;
    end

endmodule
